// ===== src/swo_pkg.sv =====
`timescale 1ns / 1ps

package swo_pkg;

   // Field widths
   localparam int TONE_W   = 16;
   localparam int RATE_W   = 17;
   localparam int SAMPLE_W = 16;

   // Divider remainder and divisor width: the widest divisor is a tone word
   localparam int DIVR_W = TONE_W;

   // Default geometry
   localparam int MAX_WAVE_SAMPLES_DEF = 512;
   localparam int SINE_TABLE_SIZE_DEF  = 1024;

   // Sample-rate register reset and sine amplitude
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(22050);
   localparam int AMPLITUDE = 32000;

   // Q30 constants for the sine table build
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   // Register port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SAMPLE_RATE = 1'b0,
      REG_UNUSED      = 1'b1
   } csr_index_type;

endpackage

// ===== src/swo_channels.sv =====
`timescale 1ns / 1ps

interface swo_req_if import swo_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TONE_W-1:0] tone_hz;

   modport source (output valid, output tone_hz, input ready);
   modport sink (input valid, input tone_hz, output ready);
endinterface

interface swo_rsp_if import swo_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ===== src/sine_wavetable_oscillator.sv =====
`timescale 1ns / 1ps
// Operation: with the tone unchanged a word takes one index division in the
//   shared restoring divider (one quotient bit per cycle), then the table read.
// A tone change first adds a period division and a cursor rescale; a zero tone skips the period division.
// Throughput: one word in flight; the next word is taken once the sample sits in the
//   output register, even while that sample still waits to be taken.
// Reset (synchronous, active high): cursor 0, period 1, last tone 1, sample rate 22050.

module sine_wavetable_oscillator import swo_pkg::*; #(
   parameter int MAX_WAVE_SAMPLES = MAX_WAVE_SAMPLES_DEF,
   parameter int SINE_TABLE_SIZE  = SINE_TABLE_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   swo_req_if.sink               req_chan,
   swo_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Derived widths
   localparam int LIMIT = MAX_WAVE_SAMPLES / 2;
   localparam int CW    = $clog2(LIMIT);
   localparam int PW    = $clog2(LIMIT + 1);
   localparam int NW    = $clog2(SINE_TABLE_SIZE + 1);
   localparam int IW    = $clog2(SINE_TABLE_SIZE);
   localparam int MB    = (PW > NW) ? PW : NW;
   localparam int PRW   = CW + MB;
   localparam int RSW   = CW + PW;
   localparam int IXW   = CW + NW;
   localparam int DW0   = (RSW > IXW) ? RSW : IXW;
   localparam int DW    = (RATE_W > DW0) ? RATE_W : DW0;
   localparam int CNT_W = $clog2(DW + 1);

   typedef logic signed [SAMPLE_W-1:0] rom_type [SINE_TABLE_SIZE];

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PDIV   = 8'b0000_0010,
      ST_RLOAD  = 8'b0000_0100,
      ST_RDIV   = 8'b0000_1000,
      ST_RSTORE = 8'b0001_0000,
      ST_ILOAD  = 8'b0010_0000,
      ST_IDIV   = 8'b0100_0000,
      ST_ROM    = 8'b1000_0000
   } state_type;

   // Build the sine table at elaboration: Q30 Taylor series, scaled to the amplitude
   function automatic rom_type build_rom();
      rom_type         rom;
      longint unsigned ph;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned mag;
      longint          sum;
      logic [1:0]      q;
      for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
         ph = longint'(k);
         ph = (ph << 32) / SINE_TABLE_SIZE;
         q = ph[31:30];
         r = ph & (ONE_Q30 - 64'd1);
         if (q[0]) begin
            r = ONE_Q30 - r;
         end
         x = (r * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         term = ((term * x2) >> 30) / 6;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 20;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 42;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 72;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 110;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 156;
         sum = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
         end
         mag = sum;
         mag = (mag * AMPLITUDE) >> 30;
         if (q[0] && r == ONE_Q30) begin
            mag = AMPLITUDE;
         end
         if (mag > AMPLITUDE) begin
            mag = AMPLITUDE;
         end
         rom[k] = q[1] ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Shifts that left-align each dividend in the divider
   localparam int SH_PERIOD = DW - RATE_W;
   localparam int SH_RESCALE = DW - RSW;
   localparam int SH_INDEX = DW - IXW;

   state_type                  state_ff, state_in;
   logic [RATE_W-1:0]          sample_rate_ff, sample_rate_in;
   logic [CW-1:0]              cursor_ff, cursor_in;
   logic [PW-1:0]              period_ff, period_in;
   logic [TONE_W-1:0]          last_tone_ff, last_tone_in;
   logic [TONE_W-1:0]          tone_ff, tone_in;
   logic [DIVR_W-1:0]          rem_ff, rem_in;
   logic [DW-1:0]              quo_ff, quo_in;
   logic [DIVR_W-1:0]          divisor_ff, divisor_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   logic                       req_fire;
   logic                       rsp_fire;
   logic                       out_free;
   logic                       csr_write;
   logic                       div_run;
   logic                       div_last;
   logic [DIVR_W:0]            trial;
   logic [PW-1:0]              np_val;
   logic [RATE_W-1:0]          np_raw;
   logic [MB-1:0]              mul_b;
   logic [PRW-1:0]             product;
   logic [PW-1:0]              cursor_inc;
   logic [IW-1:0]              rom_addr;

   // Handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = sample_ff;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   always_comb begin
      prdata = '0;
      if (csr_index_type'(paddr[2]) == REG_SAMPLE_RATE) begin
         prdata = CSR_DATA_W'(sample_rate_ff);
      end
   end

   // Shared divider: one restoring step per cycle
   assign div_run  = state_ff inside {ST_PDIV, ST_RDIV, ST_IDIV};
   assign div_last = (count_ff == CNT_W'(1));
   assign trial    = {rem_ff, quo_ff[DW-1]} - {1'b0, divisor_ff};

   // Clamp the period quotient; a zero tone goes straight to the limit
   assign np_raw = quo_ff[RATE_W-1:0];
   always_comb begin
      if (tone_ff == '0) begin
         np_val = PW'(LIMIT);
      end else if (np_raw == '0) begin
         np_val = PW'(1);
      end else if (np_raw > RATE_W'(LIMIT)) begin
         np_val = PW'(LIMIT);
      end else begin
         np_val = np_raw[PW-1:0];
      end
   end

   // Shared multiplier: cursor by new period, or cursor by table size
   assign mul_b   = (state_ff == ST_RLOAD) ? MB'(np_val) : MB'(SINE_TABLE_SIZE);
   assign product = PRW'(cursor_ff) * PRW'(mul_b);

   assign cursor_inc = PW'(cursor_ff) + PW'(1);
   assign rom_addr   = quo_ff[IW-1:0];

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      sample_rate_in = sample_rate_ff;
      cursor_in      = cursor_ff;
      period_in      = period_ff;
      last_tone_in   = last_tone_ff;
      tone_in        = tone_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      divisor_in     = divisor_ff;
      count_in       = count_ff;
      sample_in      = sample_ff;
      rsp_valid_in   = rsp_fire ? 1'b0 : rsp_valid_ff;

      if (csr_write && csr_index_type'(paddr[2]) == REG_SAMPLE_RATE) begin
         sample_rate_in = pwdata[RATE_W-1:0];
      end

      // advance the divider
      if (div_run) begin
         if (!trial[DIVR_W]) begin
            rem_in = trial[DIVR_W-1:0];
         end else begin
            rem_in = {rem_ff[DIVR_W-2:0], quo_ff[DW-1]};
         end
         quo_in   = {quo_ff[DW-2:0], !trial[DIVR_W]};
         count_in = count_ff - CNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               tone_in = req_chan.tone_hz;
               if (req_chan.tone_hz == last_tone_ff) begin
                  state_in = ST_ILOAD;
               end else if (req_chan.tone_hz == '0) begin
                  state_in = ST_RLOAD;
               end else begin
                  rem_in     = '0;
                  quo_in     = DW'(sample_rate_ff) << SH_PERIOD;
                  divisor_in = req_chan.tone_hz;
                  count_in   = CNT_W'(RATE_W);
                  state_in   = ST_PDIV;
               end
            end
         end
         ST_PDIV: begin
            if (div_last) begin
               state_in = ST_RLOAD;
            end
         end
         ST_RLOAD: begin
            // rescale the cursor against the old period
            rem_in       = '0;
            quo_in       = DW'(product[RSW-1:0]) << SH_RESCALE;
            divisor_in   = DIVR_W'(period_ff);
            count_in     = CNT_W'(RSW);
            period_in    = np_val;
            last_tone_in = tone_ff;
            state_in     = ST_RDIV;
         end
         ST_RDIV: begin
            if (div_last) begin
               state_in = ST_RSTORE;
            end
         end
         ST_RSTORE: begin
            cursor_in = quo_ff[CW-1:0];
            state_in  = ST_ILOAD;
         end
         ST_ILOAD: begin
            rem_in     = '0;
            quo_in     = DW'(product[IXW-1:0]) << SH_INDEX;
            divisor_in = DIVR_W'(period_ff);
            count_in   = CNT_W'(IXW);
            state_in   = ST_IDIV;
         end
         ST_IDIV: begin
            if (div_last) begin
               state_in = ST_ROM;
            end
         end
         ST_ROM: begin
            // hold until the output register is free
            if (out_free) begin
               sample_in    = SINE_ROM[rom_addr];
               rsp_valid_in = 1'b1;
               cursor_in    = (cursor_inc == period_ff) ? '0 : cursor_inc[CW-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sample_rate_ff <= RATE_RESET;
         cursor_ff      <= '0;
         period_ff      <= PW'(1);
         last_tone_ff   <= TONE_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sample_rate_ff <= sample_rate_in;
         cursor_ff      <= cursor_in;
         period_ff      <= period_in;
         last_tone_ff   <= last_tone_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      tone_ff    <= tone_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      sample_ff  <= sample_in;
   end

endmodule

// ===== src/swo_checker.sv =====
`timescale 1ns / 1ps

module swo_checker import swo_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample
);

   // No word is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid after reset");

   // A taken request keeps the block busy for at least the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on back-to-back cycles");

   // Samples stay within the amplitude
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample <= 16'sd32000) && (rsp_sample >= -16'sd32000))
      else $error("sample outside the amplitude");

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled response word changed");

endmodule

bind sine_wavetable_oscillator swo_checker u_swo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample)
);
